[hdl/swc_pkg.sv]
// Shared constants, types and helpers of the split/wipe frame compositor.
package swc_pkg;

	localparam int STORE_DEPTH = 65536;
	localparam int MAX_DIM     = 2048;

	localparam int STORE_AW  = $clog2(STORE_DEPTH);
	localparam int REG_W     = 12;
	localparam int IDX_W     = 3;
	localparam int PIX_W     = 32;
	localparam int DIM_W     = $clog2(MAX_DIM + 1);
	localparam int CRD_W     = $clog2(MAX_DIM);
	localparam int AREA_W    = $clog2(MAX_DIM * MAX_DIM + 1);
	localparam int CHK_W     = (AREA_W > $clog2(STORE_DEPTH + 1)) ? AREA_W
		: $clog2(STORE_DEPTH + 1);
	localparam int CMP_W     = ((REG_W > DIM_W) ? REG_W : DIM_W) + 1;
	localparam int DIV_CNT_W = $clog2(AREA_W + 1);

	localparam int CMD_DEPTH = 4;
	localparam int CMD_PW    = $clog2(CMD_DEPTH);
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PW    = $clog2(OUT_DEPTH);
	localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

	localparam logic [PIX_W-1:0] SEAM_GREEN = 32'hFF00FF00;
	localparam logic [PIX_W-1:0] EDGE_WHITE = 32'hFFFFFFFF;

	// register indexes
	localparam logic [IDX_W-1:0] REG_LAYOUT_MODE = 3'd0;
	localparam logic [IDX_W-1:0] REG_SRC_WIDTH   = 3'd1;
	localparam logic [IDX_W-1:0] REG_SRC_HEIGHT  = 3'd2;
	localparam logic [IDX_W-1:0] REG_DST_WIDTH   = 3'd3;
	localparam logic [IDX_W-1:0] REG_DST_HEIGHT  = 3'd4;
	localparam logic [IDX_W-1:0] REG_WIPE_COLUMN = 3'd5;

	// layout modes
	localparam logic [1:0] MODE_SPLIT  = 2'd0;
	localparam logic [1:0] MODE_WIPE   = 2'd1;
	localparam logic [1:0] MODE_FREEZE = 2'd2;

	localparam logic [REG_W-1:0] SRC_WIDTH_RST  = 12'd320;
	localparam logic [REG_W-1:0] SRC_HEIGHT_RST = 12'd200;
	localparam logic [REG_W-1:0] DST_WIDTH_RST  = 12'd640;
	localparam logic [REG_W-1:0] DST_HEIGHT_RST = 12'd400;
	localparam logic [REG_W-1:0] WIPE_RST       = 12'd0;

	typedef enum logic [2:0] {
		OP_WRITE,
		OP_PASS,
		OP_SOURCE,
		OP_SEAM,
		OP_EDGE,
		OP_ZERO
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [STORE_AW-1:0] addr;
		logic [PIX_W-1:0]    pixel;
		logic                eof;
	} cmd_t;

	// Clamp a dimension register to 1 .. MAX_DIM.
	function automatic logic [DIM_W-1:0] eff_dim(input logic [REG_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

endpackage

[hdl/swc_ram.sv]
// Generic single-clock RAM: one write port, one registered read port.
module swc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/swc_div.sv]
// Restoring divider, one quotient bit per cycle, used for scale set-up.
module swc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [swc_pkg::AREA_W-1:0]  num,
	input  logic [swc_pkg::DIM_W-1:0]   den,
	output logic                        done,
	output logic [swc_pkg::AREA_W-1:0]  quo,
	output logic [swc_pkg::DIM_W-1:0]   rem
);

	import swc_pkg::*;

	logic [AREA_W-1:0]    work_q;
	logic [DIM_W-1:0]     part_q;
	logic [DIM_W-1:0]     den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [DIM_W:0]       trial;
	logic                 fits;
	logic [DIM_W:0]       diff;

	assign trial = {part_q, work_q[AREA_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(AREA_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: numerator bits shift out at the top, quotient bits in at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num;
			part_q <= '0;
			den_q  <= den;
		end else if (run_q) begin
			part_q <= fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
			work_q <= {work_q[AREA_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = work_q;
	assign rem  = part_q;

endmodule

[hdl/swc_cmd_q.sv]
// Short command queue between the classifying front and the executing back.
module swc_cmd_q (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  swc_pkg::cmd_t cmd_in,
	output logic          full,
	input  logic          pop,
	output swc_pkg::cmd_t head,
	output logic          empty
);

	import swc_pkg::*;

	cmd_t              slot_q [CMD_DEPTH];
	logic [CMD_PW-1:0] wr_ptr_q;
	logic [CMD_PW-1:0] rd_ptr_q;
	logic [CMD_PW:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = cnt_q == (CMD_PW + 1)'(CMD_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == CMD_PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == CMD_PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

[hdl/swc_front.sv]
// Front end: configuration, scale set-up, raster tracking and word classification.
module swc_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [swc_pkg::IDX_W-1:0]  wr_index,
	input  logic [swc_pkg::REG_W-1:0]  wr_data,
	input  logic                       push,
	input  logic                       action,
	input  logic [swc_pkg::PIX_W-1:0]  pixel_value,
	output logic                       full,
	output logic                       q_push,
	output swc_pkg::cmd_t              q_cmd,
	input  logic                       q_full,
	output logic                       busy
);

	import swc_pkg::*;

	localparam logic [3:0] RC_IDLE   = 4'd0;
	localparam logic [3:0] RC_WRAP   = 4'd1;
	localparam logic [3:0] RC_FRAME  = 4'd2;
	localparam logic [3:0] RC_DIV_X  = 4'd3;
	localparam logic [3:0] RC_DIV_Y  = 4'd4;
	localparam logic [3:0] RC_DIV_SX = 4'd5;
	localparam logic [3:0] RC_DIV_SY = 4'd6;
	localparam logic [3:0] RC_ROW    = 4'd7;
	localparam logic [3:0] RC_STEP   = 4'd8;

	// configuration
	logic [1:0]       mode_q;
	logic [REG_W-1:0] src_w_q;
	logic [REG_W-1:0] src_h_q;
	logic [REG_W-1:0] dst_w_q;
	logic [REG_W-1:0] dst_h_q;
	logic [REG_W-1:0] wipe_q;

	// set-up sequencer and scaling state
	logic [3:0]        rc_q;
	logic              div_wait_q;
	logic [AREA_W-1:0] frame_q;
	logic [DIM_W-1:0]  qx_q;
	logic [DIM_W-1:0]  rx_q;
	logic [DIM_W-1:0]  qy_q;
	logic [DIM_W-1:0]  ry_q;
	logic [CRD_W-1:0]  col_q;
	logic [CRD_W-1:0]  row_q;
	logic [CRD_W-1:0]  sx_q;
	logic [CRD_W-1:0]  sy_q;
	logic [DIM_W-1:0]  remx_q;
	logic [DIM_W-1:0]  remy_q;
	logic [AREA_W-1:0] rowbase_q;
	logic [AREA_W-1:0] rowstep_q;
	logic [AREA_W-1:0] pos_q;

	logic [DIM_W-1:0]   sw_e;
	logic [DIM_W-1:0]   sh_e;
	logic [DIM_W-1:0]   dw_e;
	logic [DIM_W-1:0]   dh_e;
	logic               accept;
	logic               div_state;
	logic               div_start;
	logic               div_done;
	logic [AREA_W-1:0]  div_num;
	logic [DIM_W-1:0]   div_den;
	logic [AREA_W-1:0]  div_quo;
	logic [DIM_W-1:0]   div_rem;
	logic [DIM_W-1:0]   mul_a;
	logic [DIM_W-1:0]   mul_b;
	logic [2*DIM_W-1:0] prod_w;
	logic [AREA_W-1:0]  prod;

	logic               wrap_col;
	logic [DIM_W-1:0]   row_inc;
	logic [CRD_W-1:0]   row_wrapped;

	logic               last_col;
	logic               last_row;
	logic [DIM_W:0]     xsum;
	logic               cx;
	logic [DIM_W:0]     xsum_adj;
	logic [DIM_W:0]     sx_sum;
	logic [DIM_W:0]     ysum;
	logic               cy;
	logic [DIM_W:0]     ysum_adj;
	logic [DIM_W:0]     sy_sum;
	logic [AREA_W-1:0]  rowbase_n;
	logic [CHK_W-1:0]   src_idx;
	logic               src_in;
	logic [CHK_W-1:0]   pos_c;
	logic               ld_in;
	logic [AREA_W-1:0]  pos_inc;
	logic [CMP_W-1:0]   x_c;
	logic [CMP_W-1:0]   x1_c;
	logic [CMP_W-1:0]   half_c;
	logic [CMP_W-1:0]   wx_c;
	op_t                src_op;
	op_t                op_s;

	assign sw_e = eff_dim(src_w_q);
	assign sh_e = eff_dim(src_h_q);
	assign dw_e = eff_dim(dst_w_q);
	assign dh_e = eff_dim(dst_h_q);

	assign busy   = rc_q != RC_IDLE;
	assign full   = busy || q_full;
	assign accept = push && !full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_FREEZE;
			src_w_q <= SRC_WIDTH_RST;
			src_h_q <= SRC_HEIGHT_RST;
			dst_w_q <= DST_WIDTH_RST;
			dst_h_q <= DST_HEIGHT_RST;
			wipe_q  <= WIPE_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LAYOUT_MODE: mode_q  <= wr_data[1:0];
				REG_SRC_WIDTH:   src_w_q <= wr_data;
				REG_SRC_HEIGHT:  src_h_q <= wr_data;
				REG_DST_WIDTH:   dst_w_q <= wr_data;
				REG_DST_HEIGHT:  dst_h_q <= wr_data;
				REG_WIPE_COLUMN: wipe_q  <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// shared set-up multiplier
	always_comb begin
		mul_a = sw_e;
		mul_b = sh_e;
		unique case (rc_q)
			RC_DIV_SX: begin
				mul_a = DIM_W'(col_q);
				mul_b = sw_e;
			end
			RC_DIV_SY: begin
				mul_a = DIM_W'(row_q);
				mul_b = sh_e;
			end
			RC_ROW: begin
				mul_a = DIM_W'(sy_q);
				mul_b = sw_e;
			end
			RC_STEP: begin
				mul_a = qy_q;
				mul_b = sw_e;
			end
			default: begin
			end
		endcase
	end

	assign prod_w = (2 * DIM_W)'(mul_a) * (2 * DIM_W)'(mul_b);
	assign prod   = prod_w[AREA_W-1:0];

	assign div_state = (rc_q == RC_DIV_X) || (rc_q == RC_DIV_Y)
		|| (rc_q == RC_DIV_SX) || (rc_q == RC_DIV_SY);
	assign div_start = div_state && !div_wait_q && !wr_en;
	assign div_num   = (rc_q == RC_DIV_X) ? AREA_W'(sw_e)
		: (rc_q == RC_DIV_Y) ? AREA_W'(sh_e) : prod;
	assign div_den   = ((rc_q == RC_DIV_X) || (rc_q == RC_DIV_SX)) ? dw_e : dh_e;

	swc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// bring a position left outside the frame by new dimensions back in
	assign wrap_col    = DIM_W'(col_q) >= dw_e;
	assign row_inc     = DIM_W'(row_q) + DIM_W'(wrap_col);
	assign row_wrapped = (row_inc >= dh_e) ? '0 : row_inc[CRD_W-1:0];

	// incremental nearest-neighbour stepping
	assign last_col = (DIM_W'(col_q) + 1'b1) == dw_e;
	assign last_row = (DIM_W'(row_q) + 1'b1) == dh_e;
	assign xsum     = (DIM_W + 1)'(remx_q) + (DIM_W + 1)'(rx_q);
	assign cx       = xsum >= (DIM_W + 1)'(dw_e);
	assign xsum_adj = cx ? xsum - (DIM_W + 1)'(dw_e) : xsum;
	assign sx_sum   = (DIM_W + 1)'(sx_q) + (DIM_W + 1)'(qx_q) + (DIM_W + 1)'(cx);
	assign ysum     = (DIM_W + 1)'(remy_q) + (DIM_W + 1)'(ry_q);
	assign cy       = ysum >= (DIM_W + 1)'(dh_e);
	assign ysum_adj = cy ? ysum - (DIM_W + 1)'(dh_e) : ysum;
	assign sy_sum   = (DIM_W + 1)'(sy_q) + (DIM_W + 1)'(qy_q) + (DIM_W + 1)'(cy);
	assign rowbase_n = rowbase_q + rowstep_q + (cy ? AREA_W'(sw_e) : '0);

	assign src_idx = CHK_W'(rowbase_q) + CHK_W'(sx_q);
	assign src_in  = src_idx < CHK_W'(STORE_DEPTH);
	assign pos_c   = CHK_W'(pos_q);
	assign ld_in   = pos_c < CHK_W'(STORE_DEPTH);
	assign pos_inc = pos_q + 1'b1;

	// classify a stream word
	assign x_c    = CMP_W'(col_q);
	assign x1_c   = x_c + 1'b1;
	assign half_c = CMP_W'(dw_e >> 1);
	assign wx_c   = CMP_W'(wipe_q);
	assign src_op = src_in ? OP_SOURCE : OP_ZERO;

	always_comb begin
		op_s = OP_PASS;
		if (mode_q == MODE_SPLIT) begin
			if ((x_c == half_c) || (x1_c == half_c)) begin
				op_s = OP_SEAM;
			end else if (x_c < half_c) begin
				op_s = src_op;
			end
		end else if (mode_q == MODE_WIPE) begin
			if ((x_c == wx_c) || (x1_c == wx_c)) begin
				op_s = OP_EDGE;
			end else if (x_c >= wx_c) begin
				op_s = src_op;
			end
		end
	end

	always_comb begin
		q_cmd.pixel = pixel_value;
		if (action) begin
			q_cmd.op   = op_s;
			q_cmd.addr = src_idx[STORE_AW-1:0];
			q_cmd.eof  = last_col && last_row;
		end else begin
			q_cmd.op   = OP_WRITE;
			q_cmd.addr = pos_c[STORE_AW-1:0];
			q_cmd.eof  = 1'b0;
		end
	end

	// drop loads past the end of the store
	assign q_push = accept && (action || ld_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q       <= RC_WRAP;
			div_wait_q <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
			pos_q      <= '0;
			frame_q    <= '0;
			qx_q       <= '0;
			rx_q       <= '0;
			qy_q       <= '0;
			ry_q       <= '0;
			sx_q       <= '0;
			sy_q       <= '0;
			remx_q     <= '0;
			remy_q     <= '0;
			rowbase_q  <= '0;
			rowstep_q  <= '0;
		end else begin
			if (wr_en) begin
				rc_q       <= RC_WRAP;
				div_wait_q <= 1'b0;
			end else begin
				unique case (rc_q)
					RC_IDLE: begin
					end
					RC_WRAP: begin
						if (wrap_col) begin
							col_q <= '0;
						end
						row_q <= row_wrapped;
						rc_q  <= RC_FRAME;
					end
					RC_FRAME: begin
						frame_q <= prod;
						rc_q    <= RC_DIV_X;
					end
					RC_DIV_X, RC_DIV_Y, RC_DIV_SX, RC_DIV_SY: begin
						if (!div_wait_q) begin
							div_wait_q <= 1'b1;
						end else if (div_done) begin
							div_wait_q <= 1'b0;
							unique case (rc_q)
								RC_DIV_X: begin
									qx_q <= div_quo[DIM_W-1:0];
									rx_q <= div_rem;
									rc_q <= RC_DIV_Y;
								end
								RC_DIV_Y: begin
									qy_q <= div_quo[DIM_W-1:0];
									ry_q <= div_rem;
									rc_q <= RC_DIV_SX;
								end
								RC_DIV_SX: begin
									sx_q   <= div_quo[CRD_W-1:0];
									remx_q <= div_rem;
									rc_q   <= RC_DIV_SY;
								end
								default: begin
									sy_q   <= div_quo[CRD_W-1:0];
									remy_q <= div_rem;
									rc_q   <= RC_ROW;
								end
							endcase
						end
					end
					RC_ROW: begin
						rowbase_q <= prod;
						rc_q      <= RC_STEP;
					end
					RC_STEP: begin
						rowstep_q <= prod;
						rc_q      <= RC_IDLE;
					end
					default: begin
						rc_q <= RC_IDLE;
					end
				endcase
			end

			if (accept && action) begin
				if (last_col) begin
					col_q  <= '0;
					sx_q   <= '0;
					remx_q <= '0;
					if (last_row) begin
						row_q     <= '0;
						sy_q      <= '0;
						remy_q    <= '0;
						rowbase_q <= '0;
					end else begin
						row_q     <= row_q + 1'b1;
						sy_q      <= sy_sum[CRD_W-1:0];
						remy_q    <= ysum_adj[DIM_W-1:0];
						rowbase_q <= rowbase_n;
					end
				end else begin
					col_q  <= col_q + 1'b1;
					sx_q   <= sx_sum[CRD_W-1:0];
					remx_q <= xsum_adj[DIM_W-1:0];
				end
			end

			if (accept && !action) begin
				pos_q <= (pos_inc >= frame_q) ? '0 : pos_inc;
			end
		end
	end

endmodule

[hdl/swc_back.sv]
// Back end: frame store access, pixel composition and result queue.
module swc_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  swc_pkg::cmd_t             head,
	input  logic                      q_empty,
	output logic                      q_pop,
	input  logic                      pop,
	output logic                      empty,
	output logic [swc_pkg::PIX_W-1:0] out_pixel,
	output logic                      end_of_frame
);

	import swc_pkg::*;

	logic             stream_head;
	logic             room;
	logic [PIX_W-1:0] rd_data;
	logic             valid_s1;
	op_t              op_s1;
	logic [PIX_W-1:0] pixel_s1;
	logic             eof_s1;
	logic [PIX_W-1:0] comp_pix;

	logic [PIX_W-1:0]  pix_q [OUT_DEPTH];
	logic              eof_q [OUT_DEPTH];
	logic [OUT_PW-1:0] wr_ptr_q;
	logic [OUT_PW-1:0] rd_ptr_q;
	logic [OUT_CW-1:0] cnt_q;
	logic              out_pop;

	assign stream_head = head.op != OP_WRITE;
	// reserve a result slot for every stream word in flight
	assign room  = ((OUT_CW + 1)'(cnt_q) + (OUT_CW + 1)'(valid_s1))
		< (OUT_CW + 1)'(OUT_DEPTH);
	assign q_pop = !q_empty && (!stream_head || room);

	swc_ram #(
		.WIDTH (PIX_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (q_pop && (head.op == OP_WRITE)),
		.waddr (head.addr),
		.wdata (head.pixel),
		.re    (q_pop && (head.op == OP_SOURCE)),
		.raddr (head.addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= q_pop && stream_head;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_s1    <= head.op;
			pixel_s1 <= head.pixel;
			eof_s1   <= head.eof;
		end
	end

	always_comb begin
		unique case (op_s1)
			OP_SOURCE: comp_pix = rd_data;
			OP_SEAM:   comp_pix = SEAM_GREEN;
			OP_EDGE:   comp_pix = EDGE_WHITE;
			OP_ZERO:   comp_pix = '0;
			default:   comp_pix = pixel_s1;
		endcase
	end

	assign empty        = cnt_q == '0;
	assign out_pop      = pop && !empty;
	assign out_pixel    = pix_q[rd_ptr_q];
	assign end_of_frame = eof_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (valid_s1) begin
				wr_ptr_q <= (wr_ptr_q == OUT_PW'(OUT_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (out_pop) begin
				rd_ptr_q <= (rd_ptr_q == OUT_PW'(OUT_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (valid_s1 && !out_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (out_pop && !valid_s1) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			pix_q[wr_ptr_q] <= comp_pix;
			eof_q[wr_ptr_q] <= eof_s1;
		end
	end

endmodule

[hdl/split_wipe_frame_compositor_unit.sv]
// Top level of the split/wipe frame compositor: front, command queue and back.
// Throughput: one word per cycle, load or stream, while full stays low.
// An accepted stream word passes the command queue, the s1 register and the result queue.
// Reset and every register write run a scale set-up (one multiplier, four
// 23-step divisions) during which full stays high.
// Reset clears control state and loads register defaults; the store is undefined.
module split_wipe_frame_compositor_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [swc_pkg::IDX_W-1:0]  wr_index,
	input  logic [swc_pkg::REG_W-1:0]  wr_data,
	input  logic                       push,
	output logic                       full,
	input  logic                       action,
	input  logic [swc_pkg::PIX_W-1:0]  pixel_value,
	output logic                       empty,
	input  logic                       pop,
	output logic [swc_pkg::PIX_W-1:0]  out_pixel,
	output logic                       end_of_frame
);

	import swc_pkg::*;

	// Front to queue: one classified command per accepted word, loads past the store apart.
	logic q_push;
	cmd_t q_cmd;
	logic q_full;
	// Queue to back: head command and its pop.
	cmd_t q_head;
	logic q_empty;
	logic q_pop;
	logic front_busy;

	// The front holds the register file, runs the scale set-up, tracks the load
	// position and the output raster, and turns each word into a command: a store
	// write, or a stream pixel tagged with where its output comes from. Loads that
	// fall past the end of the store are dropped here and never queued.
	swc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.push        (push),
		.action      (action),
		.pixel_value (pixel_value),
		.full        (full),
		.q_push      (q_push),
		.q_cmd       (q_cmd),
		.q_full      (q_full),
		.busy        (front_busy)
	);

	// Decouple the two halves so a stalled result side does not block a load at the
	// head of the queue, and the front keeps taking words while results wait until it fills.
	swc_cmd_q u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.cmd_in (q_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.head   (q_head),
		.empty  (q_empty)
	);

	// The back executes commands in order, so a store read always sees every
	// earlier write; it composes the result word and holds it in a small queue.
	swc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.out_pixel    (out_pixel),
		.end_of_frame (end_of_frame)
	);

`ifndef SYNTHESIS
	// A register write must close the input for the set-up that follows.
	a_write_closes_input: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (full && front_busy))
		else $error("input open after register write");

	// The front never pushes a command the queue cannot hold.
	a_cmd_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command queue overflow");

	// The back never takes a command from an empty queue.
	a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command queue underflow");
`endif

endmodule

[tb/swc_checker.sv]
// Checker for the split/wipe frame compositor: predicts each composed word and compares it.
module swc_checker
	import swc_pkg::*;
#(
	parameter logic LOAD_ACTION = 1'b0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [REG_W-1:0] wr_data,
	input  logic             push,
	input  logic             full,
	input  logic             action,
	input  logic [PIX_W-1:0] pixel_value,
	input  logic             empty,
	input  logic             pop,
	input  logic [PIX_W-1:0] out_pixel,
	input  logic             end_of_frame,
	output int               fail_count,
	output int               pending_words,
	output int               words_checked,
	output int               frames_closed
);

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             eof;
	} composed_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic [REG_W-1:0] src_w;
		logic [REG_W-1:0] src_h;
		logic [REG_W-1:0] dst_w;
		logic [REG_W-1:0] dst_h;
		logic [REG_W-1:0] wipe;
	} layout_cfg_t;

	bit [PIX_W-1:0] frame_store [STORE_DEPTH];
	layout_cfg_t    cfg;
	int unsigned    load_pos;
	int unsigned    col;
	int unsigned    row;
	composed_t      expected_words [$];

	// zero reads as one, anything past the largest frame as the largest frame
	function automatic int unsigned clamp_dim(input logic [REG_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return v;
	endfunction

	function automatic logic [PIX_W-1:0] scaled_source(input int unsigned x, y, sw, sh, dw, dh);
		int unsigned sx, sy, idx;
		sx = (x * sw) / dw;
		sy = (y * sh) / dh;
		if (sx >= sw)
			sx = sw - 1;
		if (sy >= sh)
			sy = sh - 1;
		idx = sy * sw + sx;
		// past the end of the store reads as zero
		if (idx >= STORE_DEPTH)
			return '0;
		return frame_store[idx];
	endfunction

	function automatic void write_register(input logic [IDX_W-1:0] idx,
			input logic [REG_W-1:0] data);
		case (idx)
			REG_LAYOUT_MODE: cfg.mode  = data[1:0];
			REG_SRC_WIDTH:   cfg.src_w = data;
			REG_SRC_HEIGHT:  cfg.src_h = data;
			REG_DST_WIDTH:   cfg.dst_w = data;
			REG_DST_HEIGHT:  cfg.dst_h = data;
			REG_WIPE_COLUMN: cfg.wipe  = data;
			default: ;
		endcase
	endfunction

	function automatic void take_word(input logic act, input logic [PIX_W-1:0] pix);
		int unsigned sw, sh, dw, dh, x, y, half;
		composed_t   c;
		sw = clamp_dim(cfg.src_w);
		sh = clamp_dim(cfg.src_h);
		dw = clamp_dim(cfg.dst_w);
		dh = clamp_dim(cfg.dst_h);
		if (act == LOAD_ACTION) begin
			// drop writes past the store, but still advance
			if (load_pos < STORE_DEPTH)
				frame_store[load_pos] = pix;
			load_pos++;
			if (load_pos >= sw * sh)
				load_pos = 0;
			return;
		end
		// pull the raster position back inside a frame that has shrunk
		if (col >= dw) begin
			col = 0;
			row++;
		end
		if (row >= dh)
			row = 0;
		x = col;
		y = row;
		case (cfg.mode)
			MODE_SPLIT: begin
				half = dw / 2;
				c.pixel = (x < half) ? scaled_source(x, y, sw, sh, dw, dh) : pix;
				if (x == half || x + 1 == half)
					c.pixel = SEAM_GREEN;
			end
			MODE_WIPE: begin
				c.pixel = (x < cfg.wipe) ? pix : scaled_source(x, y, sw, sh, dw, dh);
				if (x == cfg.wipe || x + 1 == cfg.wipe)
					c.pixel = EDGE_WHITE;
			end
			default: c.pixel = pix;
		endcase
		c.eof = (x == dw - 1) && (y == dh - 1);
		col++;
		if (col >= dw) begin
			col = 0;
			row++;
			if (row >= dh)
				row = 0;
		end
		expected_words.push_back(c);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		composed_t want;
		if (!arst_n) begin
			cfg.mode      = MODE_FREEZE;
			cfg.src_w     = SRC_WIDTH_RST;
			cfg.src_h     = SRC_HEIGHT_RST;
			cfg.dst_w     = DST_WIDTH_RST;
			cfg.dst_h     = DST_HEIGHT_RST;
			cfg.wipe      = WIPE_RST;
			load_pos      = 0;
			col           = 0;
			row           = 0;
			expected_words.delete();
			fail_count    = 0;
			pending_words = 0;
			words_checked = 0;
			frames_closed = 0;
		end else begin
			if (wr_en)
				write_register(wr_index, wr_data);
			if (push && !full)
				take_word(action, pixel_value);
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					$error("out_pixel: expected nothing, got %08h", out_pixel);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					words_checked++;
					if (out_pixel !== want.pixel) begin
						$error("out_pixel: expected %08h, got %08h", want.pixel, out_pixel);
						fail_count++;
					end
					if (end_of_frame !== want.eof) begin
						$error("end_of_frame: expected %0b, got %0b", want.eof, end_of_frame);
						fail_count++;
					end
					if (want.eof)
						frames_closed++;
				end
			end
			pending_words = expected_words.size();
		end
	end

endmodule

[tb/tb.sv]
// Testbench top for the split/wipe frame compositor: stimulus, idling and verdict.
module tb;
	import swc_pkg::*;

	// action codes of an input word
	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_STREAM = 1'b1;
	// second passthrough code, beside MODE_FREEZE
	localparam logic [1:0] MODE_PASS_ALT = 2'd3;
	// register indexes the block does not decode
	localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

	localparam int RESET_CYCLES  = 7;
	// a scale set-up after each write keeps full high
	localparam int STALL_LIMIT   = 2000;
	// leave a margin for a load still in flight
	localparam int SETTLE_CYCLES = 6;
	// one source frame larger than the store: every entry gets written and
	// the tail is dropped, then the load position wraps
	localparam int FILL_SRC_W    = 2048;
	localparam int FILL_SRC_H    = 33;
	localparam int FILL_WORDS    = FILL_SRC_W * FILL_SRC_H + 16;
	localparam int PHASES        = 12;
	localparam int PHASE_WORDS   = 140;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             wr_en       = 1'b0;
	logic [IDX_W-1:0] wr_index    = '0;
	logic [REG_W-1:0] wr_data     = '0;
	logic             push        = 1'b0;
	logic             action      = ACT_LOAD;
	logic [PIX_W-1:0] pixel_value = '0;
	logic             pop         = 1'b0;
	logic             full;
	logic             empty;
	logic [PIX_W-1:0] out_pixel;
	logic             end_of_frame;

	int fail_count;
	int pending_words;
	int words_checked;
	int frames_closed;

	// idle percentages of each side, changed per stage of the run
	int send_idle     = 19;
	int recv_idle     = 56;
	int loads_sent    = 0;
	int streams_sent  = 0;
	int settings_made = 0;
	int quiet_cycles  = 0;

	always #5 clk = ~clk;

	split_wipe_frame_compositor_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.push         (push),
		.full         (full),
		.action       (action),
		.pixel_value  (pixel_value),
		.empty        (empty),
		.pop          (pop),
		.out_pixel    (out_pixel),
		.end_of_frame (end_of_frame)
	);

	swc_checker #(.LOAD_ACTION(ACT_LOAD)) compose_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.push          (push),
		.full          (full),
		.action        (action),
		.pixel_value   (pixel_value),
		.empty         (empty),
		.pop           (pop),
		.out_pixel     (out_pixel),
		.end_of_frame  (end_of_frame),
		.fail_count    (fail_count),
		.pending_words (pending_words),
		.words_checked (words_checked),
		.frames_closed (frames_closed)
	);

	// Receiver: decide afresh every cycle whether to take a word.
	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= recv_idle);
	end

	// Watchdog: end the run once nothing has moved for too long.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || wr_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("tb: watchdog expired after %0d quiet cycles", STALL_LIMIT);
			$display("tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Every task below starts and ends on a falling edge.

	// Offer one word, with random gaps first; hold it until accepted.
	task automatic send_word(input logic act, input logic [PIX_W-1:0] pix);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push        <= 1'b1;
		action      <= act;
		pixel_value <= pix;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
		if (act == ACT_LOAD)
			loads_sent++;
		else
			streams_sent++;
	endtask

	// Drop push, wait for every expected word, then let a trailing load finish.
	task automatic settle();
		push <= 1'b0;
		while (pending_words != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(negedge clk);
	endtask

	// Reprogram every register while the block is idle; the spare indexes
	// get random data and must be ignored.
	task automatic apply_layout(input logic [1:0] mode,
			input logic [REG_W-1:0] sw, sh, dw, dh, wipe);
		settle();
		write_reg(REG_SPARE_A, REG_W'($urandom));
		write_reg(REG_LAYOUT_MODE, REG_W'(mode));
		write_reg(REG_SRC_WIDTH, sw);
		write_reg(REG_SRC_HEIGHT, sh);
		write_reg(REG_DST_WIDTH, dw);
		write_reg(REG_DST_HEIGHT, dh);
		write_reg(REG_WIPE_COLUMN, wipe);
		write_reg(REG_SPARE_B, REG_W'($urandom));
		wr_en <= 1'b0;
		settings_made++;
	endtask

	// Mostly ordinary pixels, now and then all zeros or all ones.
	function automatic logic [PIX_W-1:0] random_pixel();
		int unsigned r;
		r = $urandom_range(15);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	// Mostly small frames so that end of frame comes often; sometimes zero,
	// the largest frame, or values past it.
	function automatic logic [REG_W-1:0] pick_dim();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 6)
			return '0;
		if (r < 12)
			return '1;
		if (r < 18)
			return REG_W'(MAX_DIM);
		if (r < 22)
			return REG_W'($urandom);
		return REG_W'($urandom_range(9, 1));
	endfunction

	// Small columns land on, just before and past the frame edge.
	function automatic logic [REG_W-1:0] pick_wipe();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		if (r < 18)
			return '1;
		if (r < 24)
			return REG_W'(MAX_DIM);
		return REG_W'($urandom_range(13));
	endfunction

	// Roughly one load in three, the rest stream words.
	task automatic run_mixed(input int n);
		repeat (n) begin
			if ($urandom_range(99) < 30)
				send_word(ACT_LOAD, random_pixel());
			else
				send_word(ACT_STREAM, random_pixel());
		end
	endtask

	initial begin
		logic [1:0] mode_pick;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. Reset layout passes the stream word through.
		send_word(ACT_STREAM, random_pixel());
		// Tiny split frame: load a whole 2x2 source (the position wraps),
		// then cover source half, seam and stream half over two rows.
		apply_layout(MODE_SPLIT, 2, 2, 6, 3, 4);
		send_word(ACT_LOAD, '1);
		send_word(ACT_LOAD, '0);
		send_word(ACT_LOAD, $urandom);
		send_word(ACT_LOAD, $urandom);
		repeat (8) send_word(ACT_STREAM, random_pixel());
		// Wipe at column 4: stream left, white edge, source right; close the
		// frame and step one column into the next.
		apply_layout(MODE_WIPE, 2, 2, 6, 3, 4);
		repeat (10) send_word(ACT_STREAM, random_pixel());
		// Zero sizes read as one pixel: the position sits outside the frame
		// and restarts on both axes; every word ends a frame.
		apply_layout(MODE_PASS_ALT, 2, 2, 0, 0, 4);
		repeat (2) send_word(ACT_STREAM, random_pixel());

		// Fill the whole store with one oversized source frame; rows past the
		// store read back as zero in the split half afterwards.
		apply_layout(MODE_SPLIT, FILL_SRC_W, FILL_SRC_H, 4, FILL_SRC_H, pick_wipe());
		repeat (FILL_WORDS) send_word(ACT_LOAD, $urandom);
		run_mixed(200);

		// Random phases; the first few pin the extremes of every register.
		for (int p = 0; p < PHASES; p++) begin
			// swap the idle profile, then run with no idling at all
			if (p == PHASES / 3) begin
				send_idle = 56;
				recv_idle = 19;
			end
			if (p == 2 * PHASES / 3) begin
				send_idle = 0;
				recv_idle = 0;
			end
			case (p)
				0: apply_layout(MODE_WIPE, 1, 1, 1, 1, 0);
				1: apply_layout(MODE_SPLIT, '1, '0, MAX_DIM, '1, MAX_DIM);
				2: apply_layout(MODE_WIPE, pick_dim(), pick_dim(), pick_dim(), pick_dim(), '1);
				3: apply_layout(MODE_PASS_ALT, pick_dim(), pick_dim(), pick_dim(), pick_dim(),
						pick_wipe());
				default: begin
					mode_pick = 2'($urandom_range(3));
					apply_layout(mode_pick, pick_dim(), pick_dim(), pick_dim(), pick_dim(),
						pick_wipe());
				end
			endcase
			run_mixed(PHASE_WORDS);
		end

		settle();
		$display("tb: pushed %0d load and %0d stream words; checked %0d results, %0d frame ends",
			loads_sent, streams_sent, words_checked, frames_closed);
		$display("tb: %0d register settings across split, wipe and passthrough layouts",
			settings_made);
		if (fail_count == 0 && pending_words == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/swc_pkg.sv
hdl/swc_ram.sv
hdl/swc_div.sv
hdl/swc_cmd_q.sv
hdl/swc_front.sv
hdl/swc_back.sv
hdl/split_wipe_frame_compositor_unit.sv
tb/swc_checker.sv
tb/tb.sv
